// ===== src/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, constants and helpers for the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH_DEF = 4096;   // default line store depth
  localparam int MAX_HEIGHT    = 4096;
  localparam int CH_W          = 8;      // bits per color channel
  localparam int NUM_CH        = 3;
  localparam int PIX_W         = CH_W * NUM_CH;
  localparam int SUM_W         = 12;     // nine 8-bit values fit in 12 bits
  localparam int POS_W         = 12;     // row / column on the output
  localparam int DIM_W         = 13;     // frame size registers
  localparam int WIDTH_RST     = 640;
  localparam int HEIGHT_RST    = 480;
  localparam int WIN_COLS      = 6;      // two stored columns of three pixels

  // divide by nine: floor(s * 3641 / 2^15) is exact for s < 2^12
  localparam int DIV9_MUL      = 3641;
  localparam int DIV9_SHIFT    = 15;
  localparam int PROD_W        = SUM_W + 12;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CH_W-1:0]  chan_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // line store / window control from the pipeline
  typedef struct packed {
    logic rd_en;   // new pixel accepted, read both stores at its column
    logic adv;     // stage 1 moves on: write back and shift the window
  } lw_ctl_t;

  // one channel of three pixels, zero extended
  function automatic sum_t chan_sum3(input pix_t a, input pix_t b, input pix_t c,
                                     input int ch);
    return SUM_W'(a[ch*CH_W +: CH_W]) + SUM_W'(b[ch*CH_W +: CH_W])
         + SUM_W'(c[ch*CH_W +: CH_W]);
  endfunction

  // truncating divide by nine through a reciprocal multiply
  function automatic chan_t div9(input sum_t s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return prod[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

// ===== src/rbb_line_win.sv =====
// ----------------------------------------------------------------------------
// rbb_line_win
// Two line stores and the 3x3 window, with per-channel nine-pixel sums.
// ----------------------------------------------------------------------------
module rbb_line_win import rbb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  lw_ctl_t                ctl,
  input  logic [ADDR_W-1:0]      rd_addr,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  pix_t                   cur_pix,   // pixel held in stage 1
  output sum_t [NUM_CH-1:0]      sums
);

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t rd_up_r;
  pix_t rd_mid_r;
  pix_t win_r [WIN_COLS];

  // read data holds until the next accepted pixel
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_up_r  <= upper_mem[rd_addr];
      rd_mid_r <= middle_mem[rd_addr];
    end
  end

  // rows move up by one at this column
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      upper_mem[wr_addr]  <= rd_mid_r;
      middle_mem[wr_addr] <= cur_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= rd_up_r;
      win_r[4] <= rd_mid_r;
      win_r[5] <= cur_pix;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sums[ch] = chan_sum3(win_r[0], win_r[1], win_r[2], ch)
               + chan_sum3(win_r[3], win_r[4], win_r[5], ch)
               + chan_sum3(rd_up_r, rd_mid_r, cur_pix, ch);
    end
  end

endmodule

// ===== src/rgb_box_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_core
// 3x3 box mean over a raster stream of RGB pixels, borders passed through.
// ----------------------------------------------------------------------------
// pipeline: a result passes the stage 1 store read, the stage 2 sums and the
//   stage 3 output register, from which it is offered
// throughput: one pixel per cycle while results are taken; a pixel in the
//   last column or last row (row, column >= 2) gives two results and holds
//   the single output port until both are taken
// reset: position counters cleared, frame size back to 640 x 480; line
//   stores and window are not cleared and hold garbage until written
module rgb_box_blur_3x3_core import rbb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input pixels
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,    // in_blue, in_green, in_red
  // results
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,   // out_row, out_col, out_blue, out_green, out_red
  output logic             out_tlast,   // last_of_item
  output logic             out_tuser,   // frame_done
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int W_RST_LAST  = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;
  localparam int H_RST_LAST  = HEIGHT_RST - 1;

  // frame size kept as last index, clamped at write time
  logic [CW-1:0] w_last_r, w_last_nxt;
  pos_t          h_last_r, h_last_nxt;

  // position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  pos_t          row_r, row_nxt;

  // stage 1: store read in flight
  logic          s1_v_r;
  pix_t          s1_pix_r;
  pos_t          s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_mean_r, s1_border_r, s1_done_r;

  // stage 2: sums registered
  logic              s2_v_r;
  sum_t [NUM_CH-1:0] s2_sum_r;
  pix_t              s2_pix_r;
  pos_t              s2_row_r;
  logic [CW-1:0]     s2_col_r;
  logic              s2_mean_r, s2_border_r, s2_done_r;

  // stage 3: output register, may hand out two results
  logic          s3_v_r;
  pix_t          s3_avg_r;
  pix_t          s3_pix_r;
  pos_t          s3_row_r;
  logic [CW-1:0] s3_col_r;
  logic          s3_mean_r, s3_border_r, s3_done_r;
  logic          s3_phase_r;   // mean already sent, border next

  logic          acc;
  logic          en1, en2, en3;
  logic          out_fire;
  logic          s3_on_last;
  lw_ctl_t       lw_ctl;
  sum_t [NUM_CH-1:0] sums;

  // position of the arriving pixel
  logic [CW-1:0] c0;
  pos_t          r0;
  logic          last_col, last_row;
  logic          p_border, p_done, p_mean;

  // --------------------------------------------------------------------------
  // register writes: always ready, clamp to legal sizes on the way in
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH: begin
          if (cfg_data < DIM_W'(3)) begin
            w_last_nxt = CW'(2);
          end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(cfg_data - 1'b1);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_data < DIM_W'(3)) begin
            h_last_nxt = POS_W'(2);
          end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
            h_last_nxt = POS_W'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = POS_W'(cfg_data - 1'b1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(W_RST_LAST);
      h_last_r <= POS_W'(H_RST_LAST);
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // flow control: each stage loads when the one after it has room
  // --------------------------------------------------------------------------
  assign s3_on_last = !(s3_mean_r && s3_border_r && !s3_phase_r);
  assign out_fire   = out_tvalid && out_tready;
  assign en3        = !s3_v_r || (out_fire && s3_on_last);
  assign en2        = !s2_v_r || en3;
  assign en1        = !s1_v_r || en2;
  assign in_tready  = en1;
  assign acc        = in_tvalid && en1;

  // --------------------------------------------------------------------------
  // position tracking; a size change mid-frame wraps the position first
  // --------------------------------------------------------------------------
  always_comb begin
    c0 = col_r;
    r0 = row_r;
    if (col_r > w_last_r) begin
      c0 = '0;
      r0 = row_r + 1'b1;
    end
    if (r0 > h_last_r) begin
      r0 = '0;
    end
    last_col = (c0 == w_last_r);
    last_row = (r0 == h_last_r);
    p_border = (r0 == '0) || last_row || (c0 == '0) || last_col;
    p_done   = last_row && last_col;
    p_mean   = (r0 >= POS_W'(2)) && (c0 >= CW'(2));

    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r0 + 1'b1;
      end else begin
        col_nxt = c0 + 1'b1;
        row_nxt = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // line stores and window; consecutive pixels never share a column, so the
  // write-back in stage 1 cannot collide with the read of the next pixel
  // --------------------------------------------------------------------------
  assign lw_ctl.rd_en = acc;
  assign lw_ctl.adv   = s1_v_r && en2;

  rbb_line_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_win (
    .clk     (clk),
    .ctl     (lw_ctl),
    .rd_addr (c0),
    .wr_addr (s1_col_r),
    .cur_pix (s1_pix_r),
    .sums    (sums)
  );

  // --------------------------------------------------------------------------
  // stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r    <= in_tdata;
      s1_row_r    <= r0;
      s1_col_r    <= c0;
      s1_mean_r   <= p_mean;
      s1_border_r <= p_border;
      s1_done_r   <= p_done;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: nine-pixel sums
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_sum_r    <= sums;
      s2_pix_r    <= s1_pix_r;
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      s2_mean_r   <= s1_mean_r;
      s2_border_r <= s1_border_r;
      s2_done_r   <= s1_done_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: divide by nine, then hold for the output handshake; pixels
  // with no result are dropped here
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r     <= 1'b0;
      s3_phase_r <= 1'b0;
    end else if (en3) begin
      s3_v_r     <= s2_v_r && (s2_mean_r || s2_border_r);
      s3_phase_r <= 1'b0;
    end else if (out_fire) begin
      s3_phase_r <= 1'b1;   // mean taken, border pixel follows
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_v_r) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s3_avg_r[ch*CH_W +: CH_W] <= div9(s2_sum_r[ch]);
      end
      s3_pix_r    <= s2_pix_r;
      s3_row_r    <= s2_row_r;
      s3_col_r    <= s2_col_r;
      s3_mean_r   <= s2_mean_r;
      s3_border_r <= s2_border_r;
      s3_done_r   <= s2_done_r;
    end
  end

  // --------------------------------------------------------------------------
  // result select: mean of the window centre first, border pixel second
  // --------------------------------------------------------------------------
  logic o_is_mean;
  pos_t o_row, o_col;
  pix_t o_pix;

  always_comb begin
    o_is_mean = s3_mean_r && !s3_phase_r;
    if (o_is_mean) begin
      o_row = s3_row_r - 1'b1;
      o_col = POS_W'(s3_col_r - 1'b1);
      o_pix = s3_avg_r;
    end else begin
      o_row = s3_row_r;
      o_col = POS_W'(s3_col_r);
      o_pix = s3_pix_r;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {o_pix, o_col, o_row};
  assign out_tlast  = s3_on_last;
  assign out_tuser  = s3_done_r;

endmodule

// ===== tb/rgb_box_blur_3x3_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_core_tb
// Self-checking bench for the 3x3 RGB box blur core. A short table of
// 3x3 frames comes first, then the start of a frame at the largest width
// narrowed in mid-row to fill the line stores, then the first rows of the
// tallest frame, then random frames of small sizes with register writes
// between frames and in mid-frame. Every result is compared against a
// cycle-free model of the line stores, the window and the position counters.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_core_tb import rbb_pkg::*; ();

  localparam int RAND_ITEMS = 600;        // random pixels to send
  localparam int DRAIN_CYC  = 8;          // wait for the core to drain, in clock cycles
  localparam int LIMIT      = 10_000_000; // watchdog, in clock cycles
  localparam int DIR_N      = 18;
  localparam int RAND_W_HI  = 32;         // usual top of random widths
  localparam int FILL_W     = RAND_W_HI * 3;  // widest random width
  localparam int WIDE_PART  = 40;         // pixels sent at the largest width
  localparam int TALL_PART  = 36;         // pixels sent at the largest height

  // one result as it leaves the core, fields in request order
  typedef struct packed {
    pos_t  row;
    pos_t  col;
    chan_t blue;
    chan_t green;
    chan_t red;
    logic  last;
    logic  done;
  } px_result_t;

  // directed row: pixel, and optionally the first result it must cause
  typedef struct packed {
    pix_t       pix;
    logic       typed;
    px_result_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [23:0]      in_tdata;    // in_blue, in_green, in_red
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;   // out_row, out_col, out_blue, out_green, out_red
  logic             out_tlast;   // last_of_item
  logic             out_tuser;   // frame_done
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [DIM_W-1:0] cfg_data;

  rgb_box_blur_3x3_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // blur model state: its own copy of the registers, stores and counters
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] frame_w_reg = DIM_W'(WIDTH_RST);
  logic [DIM_W-1:0] frame_h_reg = DIM_W'(HEIGHT_RST);
  pix_t             line_up  [MAX_WIDTH_DEF];   // row r-2
  pix_t             line_mid [MAX_WIDTH_DEF];   // row r-1
  pix_t             win_px   [WIN_COLS];        // columns c-2 and c-1
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;

  px_result_t expected_px[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;
  bit         in_burst     = 1'b0;   // sender runs back to back while set

  // directed frames, both 3x3 once the registers saturate:
  // all white (mean of 255 stays 255), then a mix of primaries and extremes
  dir_row_t dir_tab [DIR_N] = '{
    {24'hFFFFFF, 1'b1, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b0, 50'd0},
    {24'hFFFFFF, 1'b1, 12'd1, 12'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1},
    {24'h000000, 1'b1, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
    {24'hFF0000, 1'b0, 50'd0},
    {24'h00FF00, 1'b0, 50'd0},
    {24'h0000FF, 1'b0, 50'd0},
    {24'h123456, 1'b0, 50'd0},
    {24'hFEDCBA, 1'b0, 50'd0},
    {24'h808080, 1'b0, 50'd0},
    {24'h7F7F7F, 1'b0, 50'd0},
    {24'h010101, 1'b0, 50'd0}
  };

  // register value to the size actually used
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // pixels still to come before the current frame ends
  function automatic int unsigned frame_left();
    int unsigned w, h, r, c;
    w = eff_dim(frame_w_reg, MAX_WIDTH_DEF);
    h = eff_dim(frame_h_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return h * w - (r * w + c);
  endfunction

  // advance the blur model by one pixel, queue what it emits
  task automatic predict_blur(input pix_t pix, output int n_new);
    int unsigned w, h, r, c, s;
    pix_t        top, mid, mean;
    logic        border, fin;
    px_result_t  res;
    w = eff_dim(frame_w_reg, MAX_WIDTH_DEF);
    h = eff_dim(frame_h_reg, MAX_HEIGHT);
    // a register change may leave the position outside the frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r      = row_pos;
    c      = col_pos;
    top    = line_up[c];
    mid    = line_mid[c];
    border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
    fin    = (r == h - 1) && (c == w - 1);
    n_new  = 0;
    // window centered one row up and one column left is now complete
    if (r >= 2 && c >= 2) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s = top[ch*CH_W +: CH_W] + mid[ch*CH_W +: CH_W] + pix[ch*CH_W +: CH_W];
        for (int i = 0; i < WIN_COLS; i++) s += win_px[i][ch*CH_W +: CH_W];
        mean[ch*CH_W +: CH_W] = CH_W'(s / 9);
      end
      res = {pos_t'(r - 1), pos_t'(c - 1), mean[7:0], mean[15:8], mean[23:16],
             !border, fin};
      expected_px.push_back(res);
      n_new++;
    end
    // border pixels pass through after any mean
    if (border) begin
      res = {pos_t'(r), pos_t'(c), pix[7:0], pix[15:8], pix[23:16], 1'b1, fin};
      expected_px.push_back(res);
      n_new++;
    end
    for (int i = 0; i < 3; i++) win_px[i] = win_px[i+3];
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = pix;
    line_up[c]  = mid;
    line_mid[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic pix_t rand_pix();
    pix_t p;
    p = pix_t'($urandom);
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      2: begin
        for (int ch = 0; ch < NUM_CH; ch++)
          p[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return p;
  endfunction

  // register value: mostly in range, sometimes below or above it
  function automatic logic [DIM_W-1:0] rand_dim(input int unsigned hi);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return $urandom_range(0, 2);
    if (k == 1) return $urandom_range(hi + 1, hi * 3);
    return $urandom_range(3, hi);
  endfunction

  // --------------------------------------------------------------------------
  // drivers; every task starts and ends at a falling edge
  // --------------------------------------------------------------------------

  // one pixel request; a typed row overrides the first result it causes
  task automatic push_pixel(input pix_t pix, input logic typed, input px_result_t want);
    int gap, n_new;
    if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    predict_blur(pix, n_new);
    if (typed && n_new > 0) expected_px[expected_px.size() - n_new] = want;
    @(negedge clk);
  endtask

  // register write, only with the core drained
  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    // an interior pixel with no result may still be in flight
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_WIDTH) frame_w_reg = val;
    else frame_h_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: ready phases of random length, with long free-running stretches
  int rdy_hold = 0;
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold--;
    end else if ($urandom_range(0, 19) == 0) begin
      out_tready <= 1'b1;
      rdy_hold = $urandom_range(50, 300);
    end else begin
      rdy_hold = idle_len();
      if (rdy_hold > 0) begin
        out_tready <= 1'b0;
        rdy_hold--;
      end else begin
        out_tready <= 1'b1;
        rdy_hold = $urandom_range(0, 11);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check, in order against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    px_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[11:0], out_tdata[23:12], out_tdata[31:24], out_tdata[39:32],
             out_tdata[47:40], out_tlast, out_tuser};
      if (expected_px.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result row %0d col %0d rgb %h%h%h last %b done %b",
                   $realtime, got.row, got.col, got.red, got.green, got.blue,
                   got.last, got.done);
      end else begin
        want = expected_px.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch exp row %0d col %0d rgb %h%h%h last %b done %b",
                     $realtime, want.row, want.col, want.red, want.green, want.blue,
                     want.last, want.done);
            $display("  got row %0d col %0d rgb %h%h%h last %b done %b",
                     got.row, got.col, got.red, got.green, got.blue,
                     got.last, got.done);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL rgb_box_blur_3x3_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned left, rand_items;
    int          k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FRAME_WIDTH;
    cfg_data   = '0;
    rand_items = 0;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    for (int i = 0; i < WIN_COLS; i++) win_px[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // both registers below range, saturate to a 3x3 frame
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(2));
    for (int i = 0; i < DIR_N; i++)
      push_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);

    // widest frame: all-ones width saturates to the store depth, so the
    // first row runs on without wrapping
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(3));
    repeat (WIDE_PART) push_pixel(rand_pix(), 1'b0, '0);

    // narrow in mid-row to the widest random width and finish the frame;
    // this fills every store entry that the random frames can reach
    write_reg(CFG_FRAME_WIDTH, DIM_W'(FILL_W));
    left = frame_left();
    repeat (left) push_pixel(rand_pix(), 1'b0, '0);

    // tallest frame, first rows only
    write_reg(CFG_FRAME_WIDTH, DIM_W'(3));
    write_reg(CFG_FRAME_HEIGHT, '1);
    repeat (TALL_PART) push_pixel(rand_pix(), 1'b0, '0);

    // random small frames, some cut short by a register write in mid-frame
    while (rand_items < RAND_ITEMS) begin
      k = $urandom_range(0, 3);
      if (k != 0) write_reg(CFG_FRAME_WIDTH, rand_dim(RAND_W_HI));
      if (k != 1) write_reg(CFG_FRAME_HEIGHT, rand_dim(8));
      left = frame_left();
      if ($urandom_range(0, 3) == 0 && left > 1) left = $urandom_range(1, left - 1);
      if (left > RAND_ITEMS - rand_items) left = RAND_ITEMS - rand_items;
      repeat (left) push_pixel(rand_pix(), 1'b0, '0);
      rand_items += left;
    end

    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC * 2) @(posedge clk);
    if (mismatch_cnt == 0 && expected_px.size() == 0)
      $display("PASS rgb_box_blur_3x3_core");
    else
      $display("FAIL rgb_box_blur_3x3_core");
    $finish;
  end

endmodule
